// ----- design/vertex_axis_rotation_defines.svh -----
// Assertion helpers shared by the vertex rotation design files.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef VERTEX_AXIS_ROTATION_DEFINES_SVH
`define VERTEX_AXIS_ROTATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VXR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vertex_axis_rotation: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define VXR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vertex_axis_rotation: next-cycle check failed");

`endif

// ----- design/vxr_pkg.sv -----
package vxr_pkg;

  // Default widths.
  localparam int COORD_BITS_DEF     = 16;
  localparam int TRIG_FRAC_BITS_DEF = 14;
  localparam int OUT_BITS           = 18;

  // Configuration port.
  localparam int ANGLE_W     = 12;
  localparam int AXIS_W      = 3;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_ANGLE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS  = 1'd1;

  // Bit positions in the axis select register.
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  // Angle units are tenths of a degree.
  localparam int ANGLE_HALF_TURN = 1800;
  localparam int ANGLE_QUARTER   = ANGLE_HALF_TURN / 2;
  localparam int ANGLE_FULL      = 2 * ANGLE_HALF_TURN;

  // Quarter-wave sine table: 10-bit index split into four banks of 256.
  localparam int TAB_IDX_W  = 10;
  localparam int TAB_BANK_W = 2;
  localparam int TAB_OFF_W  = 8;
  localparam int TAB_BANKS  = 1 << TAB_BANK_W;
  localparam int TAB_DEPTH  = 1 << TAB_OFF_W;

  // Cycles from an angle change until sine and cosine are valid.
  localparam int TRIG_LAT = 3;

  // Pi in unsigned Q60 and the angle step of one tenth of a degree.
  localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
  localparam logic [63:0] THETA_STEP = PI_Q60 / ANGLE_HALF_TURN;

  // floor(a * b / 2^60), kept to 64 bits.
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // floor(n / d) by restoring long division; only evaluated while building
  // the constant tables.
  function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], n[i]};
      if (rem >= {1'b0, d}) begin
        rem  = rem - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sine of r tenths of a degree, first quadrant, rounded to frac bits.
  // Alternating Taylor series in Q60; used only to build constant tables.
  function automatic logic [63:0] quarter_sine(input int unsigned r, input int unsigned frac);
    logic [63:0] theta;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] den;
    int unsigned shift;
    theta = THETA_STEP * 64'(r);
    x2    = mul_q60(theta, theta);
    term  = theta;
    sum   = theta;
    shift = 60 - frac;
    for (int k = 1; k < 24; k++) begin
      den  = 64'(2 * k) * 64'(2 * k + 1);
      term = div_u64(mul_q60(term, x2), den);
      if ((k & 1) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return (sum + (64'd1 << (shift - 1))) >> shift;
  endfunction

endpackage

// ----- design/vertex_axis_rotation.sv -----
// Channel  Direction  Handshake             Word
// cfg      in         cfg_we                cfg_index, cfg_wdata
// in       in         in_valid / in_ready   in_x, in_y, in_z
// out      out        out_valid / out_ready out_x, out_y, out_z
//
// One vertex word per cycle while out_ready is high and sine and cosine have settled;
// each word passes six register stages, two per axis (one multiply stage and one sum
// stage, always all three axes), and out_valid rises when it reaches the last sum stage.
// Sine and cosine come from a three-stage table lookup off the angle register, so
// in_ready stays low after reset and after each configuration write until they settle.
// Synchronous reset clears the configuration and valid bits and reloads the settle count.
// A stall on out_ready fills the stages from the output back; nothing is lost or repeated.
`include "vertex_axis_rotation_defines.svh"

module vertex_axis_rotation #(
  parameter int COORD_BITS     = vxr_pkg::COORD_BITS_DEF,
  parameter int TRIG_FRAC_BITS = vxr_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [vxr_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [vxr_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_BITS-1:0]          in_x,
  input  logic signed [COORD_BITS-1:0]          in_y,
  input  logic signed [COORD_BITS-1:0]          in_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [vxr_pkg::OUT_BITS-1:0]   out_x,
  output logic signed [vxr_pkg::OUT_BITS-1:0]   out_y,
  output logic signed [vxr_pkg::OUT_BITS-1:0]   out_z
);
  import vxr_pkg::*;

  localparam int COORD_W = COORD_BITS + 2;
  localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
  localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1) << TRIG_FRAC_BITS;

  logic [ANGLE_W-1:0] angle_r, angle_nxt;
  logic [AXIS_W-1:0]  axis_r, axis_nxt;

  logic signed [TRIG_W-1:0] sin_s, cos_s;
  logic trig_ok;
  logic trig_in_range;

  logic x_in_valid, x_in_ready, xy_valid, xy_ready, yz_valid, yz_ready;
  logic signed [COORD_W-1:0] x0, y0, z0, x1, y1, z1, x2, y2, z2, x3, y3, z3;

  // Configuration registers.
  always_comb begin
    angle_nxt = angle_r;
    axis_nxt  = axis_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ANGLE: angle_nxt = cfg_wdata[ANGLE_W-1:0];
        REG_AXIS:  axis_nxt  = cfg_wdata[AXIS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      axis_r  <= '0;
    end else begin
      angle_r <= angle_nxt;
      axis_r  <= axis_nxt;
    end
  end

  vxr_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (cfg_we),
    .angle   (angle_r),
    .sin_o   (sin_s),
    .cos_o   (cos_s),
    .ready_o (trig_ok)
  );

  // Hold off input words until sine and cosine match the angle register.
  assign x_in_valid = in_valid && trig_ok && !cfg_we;
  assign in_ready   = x_in_ready && trig_ok && !cfg_we;

  assign x0 = COORD_W'(in_x);
  assign y0 = COORD_W'(in_y);
  assign z0 = COORD_W'(in_z);

  // About X: (u, v) = (y, z).
  vxr_axis #(.COORD_W(COORD_W), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (axis_r[AXIS_X]),
    .sin_i     (sin_s),
    .cos_i     (cos_s),
    .in_valid  (x_in_valid),
    .in_ready  (x_in_ready),
    .in_u      (y0),
    .in_v      (z0),
    .in_w      (x0),
    .out_valid (xy_valid),
    .out_ready (xy_ready),
    .out_u     (y1),
    .out_v     (z1),
    .out_w     (x1)
  );

  // About Y: (u, v) = (z, x).
  vxr_axis #(.COORD_W(COORD_W), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (axis_r[AXIS_Y]),
    .sin_i     (sin_s),
    .cos_i     (cos_s),
    .in_valid  (xy_valid),
    .in_ready  (xy_ready),
    .in_u      (z1),
    .in_v      (x1),
    .in_w      (y1),
    .out_valid (yz_valid),
    .out_ready (yz_ready),
    .out_u     (z2),
    .out_v     (x2),
    .out_w     (y2)
  );

  // About Z: (u, v) = (x, y).
  vxr_axis #(.COORD_W(COORD_W), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (axis_r[AXIS_Z]),
    .sin_i     (sin_s),
    .cos_i     (cos_s),
    .in_valid  (yz_valid),
    .in_ready  (yz_ready),
    .in_u      (x2),
    .in_v      (y2),
    .in_w      (z2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_u     (x3),
    .out_v     (y3),
    .out_w     (z3)
  );

  assign out_x = OUT_BITS'(x3);
  assign out_y = OUT_BITS'(y3);
  assign out_z = OUT_BITS'(z3);

  // Sine and cosine both lie within plus or minus one.
  assign trig_in_range = (sin_s <= TRIG_ONE) && (sin_s >= -TRIG_ONE) &&
                         (cos_s <= TRIG_ONE) && (cos_s >= -TRIG_ONE);

  // A configuration write always blocks the input on the following cycle.
  `VXR_ASSERT_NXT(a_cfg_blocks_input, cfg_we, !in_ready)
  // Settled sine and cosine stay within plus or minus one.
  `VXR_ASSERT_IMP(a_trig_range, trig_ok, trig_in_range)
  // The first stage only blocks when the whole pipe is full and stalled.
  `VXR_ASSERT_IMP(a_full_when_blocked, !x_in_ready, out_valid && !out_ready)

endmodule

// ----- design/vxr_trig.sv -----
module vxr_trig #(
  parameter int TRIG_FRAC_BITS = vxr_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  logic [vxr_pkg::ANGLE_W-1:0]         angle,
  output logic signed [TRIG_FRAC_BITS+1:0]    sin_o,
  output logic signed [TRIG_FRAC_BITS+1:0]    cos_o,
  output logic                                ready_o
);
  import vxr_pkg::*;

  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int MAG_W  = TRIG_FRAC_BITS + 1;
  localparam int CNT_W  = $clog2(TRIG_LAT + 1);

  // Constant quarter-wave table, one bank per top index pair.
  logic [MAG_W-1:0] tab [TAB_BANKS][TAB_DEPTH];

  for (genvar b = 0; b < TAB_BANKS; b++) begin : g_bank
    for (genvar o = 0; o < TAB_DEPTH; o++) begin : g_ent
      localparam logic [63:0] VAL = quarter_sine(b * TAB_DEPTH + o, TRIG_FRAC_BITS);
      assign tab[b][o] = VAL[MAG_W-1:0];
    end
  end

  logic [TAB_IDX_W-1:0] s_idx_r, s_idx_nxt, c_idx_r, c_idx_nxt;
  logic                 s_neg_r, s_neg_nxt, c_neg_r, c_neg_nxt;
  logic [MAG_W-1:0]     s_bank_r [TAB_BANKS];
  logic [MAG_W-1:0]     c_bank_r [TAB_BANKS];
  logic [TAB_BANK_W-1:0] s_sel_r, c_sel_r;
  logic                 s_neg2_r, c_neg2_r;
  logic signed [TRIG_W-1:0] sin_r, sin_nxt, cos_r, cos_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  // Stage 0: wrap the angle, find the quadrant and the table indexes.
  always_comb begin
    logic [ANGLE_W-1:0]   a_mod;
    logic [ANGLE_W-1:0]   base;
    logic [ANGLE_W-1:0]   r_full;
    logic [TAB_IDX_W-1:0] r;
    logic [1:0]           q;
    logic [1:0]           cq;
    a_mod = (angle >= ANGLE_W'(ANGLE_FULL)) ? angle - ANGLE_W'(ANGLE_FULL) : angle;
    if (a_mod >= ANGLE_W'(3 * ANGLE_QUARTER)) begin
      q    = 2'd3;
      base = ANGLE_W'(3 * ANGLE_QUARTER);
    end else if (a_mod >= ANGLE_W'(2 * ANGLE_QUARTER)) begin
      q    = 2'd2;
      base = ANGLE_W'(2 * ANGLE_QUARTER);
    end else if (a_mod >= ANGLE_W'(ANGLE_QUARTER)) begin
      q    = 2'd1;
      base = ANGLE_W'(ANGLE_QUARTER);
    end else begin
      q    = 2'd0;
      base = '0;
    end
    r_full = a_mod - base;
    r      = r_full[TAB_IDX_W-1:0];
    // Cosine is the sine one quadrant further on.
    cq        = q + 2'd1;
    s_idx_nxt = q[0]  ? TAB_IDX_W'(ANGLE_QUARTER) - r : r;
    c_idx_nxt = cq[0] ? TAB_IDX_W'(ANGLE_QUARTER) - r : r;
    s_neg_nxt = q[1];
    c_neg_nxt = cq[1];
  end

  // Stage 2: pick the bank and apply the sign.
  always_comb begin
    logic [MAG_W-1:0] s_mag;
    logic [MAG_W-1:0] c_mag;
    s_mag   = s_bank_r[s_sel_r];
    c_mag   = c_bank_r[c_sel_r];
    sin_nxt = s_neg2_r ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
    cos_nxt = c_neg2_r ? -$signed({1'b0, c_mag}) : $signed({1'b0, c_mag});
  end

  // Settle counter: restarts on reset and on every configuration write.
  always_comb begin
    if (load) begin
      cnt_nxt = CNT_W'(TRIG_LAT);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= CNT_W'(TRIG_LAT);
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Lookup pipeline; runs every cycle from the angle register.
  always_ff @(posedge clk) begin
    s_idx_r  <= s_idx_nxt;
    c_idx_r  <= c_idx_nxt;
    s_neg_r  <= s_neg_nxt;
    c_neg_r  <= c_neg_nxt;
    for (int b = 0; b < TAB_BANKS; b++) begin
      s_bank_r[b] <= tab[b][s_idx_r[TAB_OFF_W-1:0]];
      c_bank_r[b] <= tab[b][c_idx_r[TAB_OFF_W-1:0]];
    end
    s_sel_r  <= s_idx_r[TAB_IDX_W-1:TAB_OFF_W];
    c_sel_r  <= c_idx_r[TAB_IDX_W-1:TAB_OFF_W];
    s_neg2_r <= s_neg_r;
    c_neg2_r <= c_neg_r;
    sin_r    <= sin_nxt;
    cos_r    <= cos_nxt;
  end

  assign sin_o   = sin_r;
  assign cos_o   = cos_r;
  assign ready_o = (cnt_r == '0);

endmodule

// ----- design/vxr_axis.sv -----
// One plane rotation when enabled: u' = c*u - s*v, v' = s*u + c*v, w passes.
// Two register stages: products, then sum with truncation toward zero.
module vxr_axis #(
  parameter int COORD_W        = vxr_pkg::COORD_BITS_DEF + 2,
  parameter int TRIG_FRAC_BITS = vxr_pkg::TRIG_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              enable,
  input  logic signed [TRIG_FRAC_BITS+1:0]  sin_i,
  input  logic signed [TRIG_FRAC_BITS+1:0]  cos_i,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_W-1:0]         in_u,
  input  logic signed [COORD_W-1:0]         in_v,
  input  logic signed [COORD_W-1:0]         in_w,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [COORD_W-1:0]         out_u,
  output logic signed [COORD_W-1:0]         out_v,
  output logic signed [COORD_W-1:0]         out_w
);
  import vxr_pkg::*;

  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int PROD_W = COORD_W + TRIG_W;
  localparam int SUM_W  = PROD_W + 1;

  logic st1_vld_r, st1_vld_nxt, st2_vld_r, st2_vld_nxt;
  logic load1, load2;
  logic signed [PROD_W-1:0] cu_r, cu_nxt, sv_r, sv_nxt, su_r, su_nxt, cv_r, cv_nxt;
  logic signed [COORD_W-1:0] u1_r, v1_r, w1_r;
  logic signed [COORD_W-1:0] u2_r, u2_nxt, v2_r, v2_nxt, w2_r;

  // Divide by 2^frac, truncating toward zero.
  function automatic logic signed [COORD_W-1:0] trunc_div(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] t;
    t = s + (s[SUM_W-1] ? {{(SUM_W-TRIG_FRAC_BITS){1'b0}}, {TRIG_FRAC_BITS{1'b1}}} : '0);
    t = t >>> TRIG_FRAC_BITS;
    return t[COORD_W-1:0];
  endfunction

  // A stage loads when it is empty or its word moves on.
  assign load2    = !st2_vld_r || out_ready;
  assign load1    = !st1_vld_r || load2;
  assign in_ready = load1;

  assign st1_vld_nxt = load1 ? in_valid  : st1_vld_r;
  assign st2_vld_nxt = load2 ? st1_vld_r : st2_vld_r;

  // Stage 1 products.
  assign cu_nxt = PROD_W'(cos_i) * PROD_W'(in_u);
  assign sv_nxt = PROD_W'(sin_i) * PROD_W'(in_v);
  assign su_nxt = PROD_W'(sin_i) * PROD_W'(in_u);
  assign cv_nxt = PROD_W'(cos_i) * PROD_W'(in_v);

  // Stage 2 sums; an unselected axis passes the coordinates through.
  always_comb begin
    if (enable) begin
      u2_nxt = trunc_div(SUM_W'(cu_r) - SUM_W'(sv_r));
      v2_nxt = trunc_div(SUM_W'(su_r) + SUM_W'(cv_r));
    end else begin
      u2_nxt = u1_r;
      v2_nxt = v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_vld_r <= 1'b0;
      st2_vld_r <= 1'b0;
    end else begin
      st1_vld_r <= st1_vld_nxt;
      st2_vld_r <= st2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      cu_r <= cu_nxt;
      sv_r <= sv_nxt;
      su_r <= su_nxt;
      cv_r <= cv_nxt;
      u1_r <= in_u;
      v1_r <= in_v;
      w1_r <= in_w;
    end
    if (load2) begin
      u2_r <= u2_nxt;
      v2_r <= v2_nxt;
      w2_r <= w1_r;
    end
  end

  assign out_valid = st2_vld_r;
  assign out_u     = u2_r;
  assign out_v     = v2_r;
  assign out_w     = w2_r;

endmodule

// ----- verif/tb_vertex_axis_rotation.sv -----
`timescale 1ns / 100ps

module tb_vertex_axis_rotation;
  import vxr_pkg::*;

  localparam int CW          = COORD_BITS_DEF;
  localparam int FRAC        = TRIG_FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SEGMENTS    = 16;
  localparam int SEG_WORDS   = 50;
  localparam int DRAIN_WAIT  = 12;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] y;
    logic signed [OUT_BITS-1:0] z;
  } rotated_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CFG_INDEX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wdata;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [CW-1:0]       in_x = '0;
  logic signed [CW-1:0]       in_y = '0;
  logic signed [CW-1:0]       in_z = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [OUT_BITS-1:0] out_x;
  logic signed [OUT_BITS-1:0] out_y;
  logic signed [OUT_BITS-1:0] out_z;

  // Vertices waiting to be driven and rotations waiting to come out.
  vertex_t  vertex_q[$];
  rotated_t rotated_q[$];
  vertex_t  next_vertex;

  // Shadow of the configuration registers.
  logic [ANGLE_W-1:0] shadow_angle;
  logic [AXIS_W-1:0]  shadow_axes;

  int sine_q14 [0:ANGLE_QUARTER];
  int fed_cnt;
  int accepted_cnt = 0;
  int checked_cnt = 0;
  int mismatch_cnt = 0;
  int settings_cnt;
  int cycle_cnt = 0;
  int idle_pct;
  int stall_pct;
  logic in_taken = 1'b0;

  vertex_axis_rotation uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_z     (out_z)
  );

  always #4 clk = ~clk;

  // Q60 product, floor(a * b / 2^60).
  function automatic logic [63:0] frac_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // First-quadrant sine of r tenths of a degree by a Taylor series in Q60,
  // rounded half up to FRAC fraction bits.
  function automatic int taylor_sine(input int unsigned r);
    logic [63:0] theta;
    logic [63:0] theta_sq;
    logic [63:0] term;
    logic [63:0] acc;
    theta    = (PI_Q60 / 64'(ANGLE_HALF_TURN)) * 64'(r);
    theta_sq = frac_mul(theta, theta);
    term     = theta;
    acc      = theta;
    for (int k = 1; k < 24 && term != 64'd0; k++) begin
      term = frac_mul(term, theta_sq) / (64'(2 * k) * 64'(2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - term;
      end else begin
        acc = acc + term;
      end
    end
    acc = (acc + (64'd1 << (59 - FRAC))) >> (60 - FRAC);
    return int'(acc);
  endfunction

  // Full-circle sine from the quarter table; the angle wraps at a full turn.
  function automatic int trig_sine(input int unsigned a);
    int unsigned quad;
    int unsigned rem;
    int          mag;
    a    = a % ANGLE_FULL;
    quad = a / ANGLE_QUARTER;
    rem  = a % ANGLE_QUARTER;
    mag  = (quad % 2 == 1) ? sine_q14[ANGLE_QUARTER - rem] : sine_q14[rem];
    return (quad >= 2) ? -mag : mag;
  endfunction

  // Sum of two products scaled down, truncated toward zero.
  function automatic longint frac_mix(input longint p, input longint a,
                                      input longint q, input longint b);
    longint one;
    one = longint'(1) << FRAC;
    return (p * a + q * b) / one;
  endfunction

  // Rotation about X, then Y, then Z for each selected axis.
  function automatic rotated_t rotate_vertex(input vertex_t v,
                                             input logic [ANGLE_W-1:0] ang,
                                             input logic [AXIS_W-1:0] axes);
    longint   x, y, z, s, c, t1, t2;
    rotated_t r;
    x = v.x;
    y = v.y;
    z = v.z;
    if (axes != '0) begin
      s = trig_sine(int'(ang));
      c = trig_sine(int'(ang) + ANGLE_QUARTER);
      if (axes[AXIS_X]) begin
        t1 = frac_mix(c, y, -s, z);
        t2 = frac_mix(s, y, c, z);
        y  = t1;
        z  = t2;
      end
      if (axes[AXIS_Y]) begin
        t1 = frac_mix(c, x, s, z);
        t2 = frac_mix(c, z, -s, x);
        x  = t1;
        z  = t2;
      end
      if (axes[AXIS_Z]) begin
        t1 = frac_mix(c, x, -s, y);
        t2 = frac_mix(s, x, c, y);
        x  = t1;
        y  = t2;
      end
    end
    r.x = x[OUT_BITS-1:0];
    r.y = y[OUT_BITS-1:0];
    r.z = z[OUT_BITS-1:0];
    return r;
  endfunction

  // Random coordinate with a bias toward the extremes.
  function automatic logic signed [CW-1:0] pick_coord();
    case ($urandom_range(7))
      0: return {1'b1, {(CW-1){1'b0}}};
      1: return {1'b0, {(CW-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return CW'($urandom);
    endcase
  endfunction

  // Wait at falling edges until every vertex fed has come back out.
  task automatic wait_drained();
    do @(negedge clk);
    while (accepted_cnt != fed_cnt || rotated_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_ANGLE) begin
      shadow_angle = val[ANGLE_W-1:0];
    end else begin
      shadow_axes = val[AXIS_W-1:0];
    end
  endtask

  // Reprogram both registers once the pipeline is empty, then hand back at a
  // rising edge so new vertices are queued away from the driver's edge.
  task automatic apply_setting(input int ang, input int axes, input int idle, input int stall);
    wait_drained();
    write_reg(REG_ANGLE, CFG_DATA_W'(ang));
    write_reg(REG_AXIS, CFG_DATA_W'(axes));
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    idle_pct  = idle;
    stall_pct = stall;
    settings_cnt++;
  endtask

  task automatic feed_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic signed [CW-1:0] z);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    vertex_q.push_back(v);
    fed_cnt++;
  endtask

  task automatic feed_extremes();
    feed_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    feed_vertex(16'sh8000, 16'sh8000, 16'sh8000);
    feed_vertex(16'sh0000, 16'sh0000, 16'sh0000);
    feed_vertex(16'sh8000, 16'sh7FFF, 16'shFFFF);
    feed_vertex(16'sh0001, 16'shFFFF, 16'sh3039);
  endtask

  // Driver: a new word goes out at the falling edge once the last one is taken.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (vertex_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_vertex = vertex_q.pop_front();
        in_valid <= 1'b1;
        in_x     <= next_vertex.x;
        in_y     <= next_vertex.y;
        in_z     <= next_vertex.z;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: predict on each accepted vertex, check each accepted result.
  always @(posedge clk) begin
    rotated_t expd;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        rotated_q.push_back(rotate_vertex({in_x, in_y, in_z}, shadow_angle, shadow_axes));
        accepted_cnt++;
      end
      if (out_valid && out_ready) begin
        checked_cnt++;
        if (rotated_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("ERROR: unexpected result (%0d, %0d, %0d)", out_x, out_y, out_z);
          end
        end else begin
          expd = rotated_q.pop_front();
          if (out_x !== expd.x || out_y !== expd.y || out_z !== expd.z) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("ERROR: result %0d expected (%0d, %0d, %0d) got (%0d, %0d, %0d)",
                       checked_cnt, expd.x, expd.y, expd.z, out_x, out_y, out_z);
            end
          end
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int ang;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    shadow_angle = '0;
    shadow_axes  = '0;
    fed_cnt      = 0;
    settings_cnt = 0;
    idle_pct     = 0;
    stall_pct    = 0;
    for (int r = 0; r <= ANGLE_QUARTER; r++) begin
      sine_q14[r] = taylor_sine(r);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings pass vertices through unchanged, then the
    // largest angle, an angle past a full turn that must wrap, and single axes.
    feed_extremes();
    apply_setting(ANGLE_FULL - 1, 7, 0, 0);
    feed_extremes();
    apply_setting(4095, 7, 0, 0);
    feed_extremes();
    apply_setting(ANGLE_QUARTER, 1 << AXIS_Y, 0, 0);
    feed_extremes();
    apply_setting(ANGLE_QUARTER / 2, 1 << AXIS_Z, 0, 0);
    feed_extremes();

    // Random segments, each with its own angle, axis mix and idle pattern.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case ($urandom_range(5))
        0: ang = $urandom_range(4095, ANGLE_FULL);
        1: ang = ANGLE_QUARTER * $urandom_range(4);
        default: ang = $urandom_range(ANGLE_FULL - 1, 0);
      endcase
      case (seg % 4)
        0: apply_setting(ang, (seg * 3) % 8, 0, 0);
        1: apply_setting(ang, (seg * 3) % 8, 55, 0);
        2: apply_setting(ang, (seg * 3) % 8, 0, 55);
        default: apply_setting(ang, (seg * 3) % 8, 28, 28);
      endcase
      for (int n = 0; n < SEG_WORDS; n++) begin
        feed_vertex(pick_coord(), pick_coord(), pick_coord());
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Rotated %0d vertices under %0d angle/axis settings, with sender gaps and",
             accepted_cnt, settings_cnt + 1);
    $display("receiver stalls of 0, 28 and 55 percent; %0d mismatches", mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
